// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module.
// Clock and reset are taken from clk_i and rst_ni in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked out of reset.
`define ITCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked only on cycles where the given valid is high.
`define ITCS_ASSERT_WHEN(lbl, vld, prop, msg) \
  `ITCS_ASSERT(lbl, (vld) |-> (prop), msg)

`endif

// ===== rtl/itcs_pkg.sv =====
// ----------------------------------------------------------------------------
// itcs_pkg
// Types, codes and constants of the ice tray cycle sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package itcs_pkg;

  // Field and register widths
  localparam int unsigned TempW    = 12;
  localparam int unsigned ValveW   = 8;
  localparam int unsigned RotW     = 6;
  localparam int unsigned MotorW   = 2;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 12;

  // Register reset values
  localparam logic [TempW-1:0]  ThresholdRst = TempW'(250);
  localparam logic [ValveW-1:0] FillLimitRst = ValveW'(7);
  localparam logic [RotW-1:0]   WinStartRst  = RotW'(2);
  localparam logic [RotW-1:0]   WinEndRst    = RotW'(3);

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegThreshold = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegFillLimit = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegWinStart  = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegWinEnd    = CfgIdxW'(3);

  // Input kinds
  localparam logic KindTick = 1'b0;
  localparam logic KindPoll = 1'b1;

  // Rotation schedule boundaries (last tick of each phase)
  localparam logic [RotW-1:0] SchedFwdEnd    = RotW'(3);
  localparam logic [RotW-1:0] EmptyFwdEnd    = RotW'(8);
  localparam logic [RotW-1:0] EmptyStop1End  = RotW'(10);
  localparam logic [RotW-1:0] EmptyRevEnd    = RotW'(18);
  localparam logic [RotW-1:0] EmptyStop2End  = RotW'(20);
  localparam logic [RotW-1:0] FullStop1End   = RotW'(5);
  localparam logic [RotW-1:0] FullRevEnd     = RotW'(9);
  localparam logic [RotW-1:0] FullStop2End   = RotW'(11);
  localparam logic [RotW-1:0] IdleRotWrap    = RotW'(20);

  typedef enum logic [MotorW-1:0] {
    MotorStop = 2'd0,
    MotorFwd  = 2'd1,
    MotorRev  = 2'd2
  } motor_e;

  // Result item
  typedef struct packed {
    logic [MotorW-1:0] motor_drive;
    logic              valve_open;
    logic              water_filled;
    logic              rotating;
    logic              hall_seen;
    logic              bin_full;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/itcs_if.sv =====
// ----------------------------------------------------------------------------
// itcs_if
// Valid/ready channels of the ice tray cycle sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

interface itcs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic                          hall_level;
  logic [itcs_pkg::TempW-1:0]    temp_reading;

  modport source (output valid, kind, hall_level, temp_reading, input ready);
  modport sink   (input valid, kind, hall_level, temp_reading, output ready);
endinterface

interface itcs_out_if;
  logic                          valid;
  logic                          ready;
  logic [itcs_pkg::MotorW-1:0]   motor_drive;
  logic                          valve_open;
  logic                          water_filled;
  logic                          rotating;
  logic                          hall_seen;
  logic                          bin_full;

  modport source (output valid, motor_drive, valve_open, water_filled, rotating,
                  hall_seen, bin_full, input ready);
  modport sink   (input valid, motor_drive, valve_open, water_filled, rotating,
                  hall_seen, bin_full, output ready);
endinterface

interface itcs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [itcs_pkg::CfgIdxW-1:0]  index;
  logic [itcs_pkg::CfgDataW-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/ice_tray_cycle_sequencer.sv =====
// ----------------------------------------------------------------------------
// ice_tray_cycle_sequencer
// Ice maker fill / harvest sequencer driven by tick and poll transfers.
// ----------------------------------------------------------------------------
// Every input transfer (a timer tick or a control poll) produces exactly one
// result transfer showing the motor, valve and cycle flags after that item.
// The block takes one item per clock: the whole update is combinational
// compares and small counter steps, and the result lands in an output
// register, so a new item is taken whenever that register is empty or is
// being drained in the same cycle; its result is offered in the next cycle.
// Configuration writes are always taken (cfg ready is always high) and
// should only be issued while no result is pending; indexes beyond the four
// registers are dropped and data is trimmed to each register's width.
// ----------------------------------------------------------------------------
`default_nettype none

module ice_tray_cycle_sequencer (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  itcs_in_if.sink        in_i,
  itcs_out_if.source     out_o,
  itcs_cfg_if.sink       cfg_i
);

  // Configuration registers
  logic [itcs_pkg::TempW-1:0]  threshold_q;
  logic [itcs_pkg::ValveW-1:0] fill_limit_q;
  logic [itcs_pkg::RotW-1:0]   win_start_q;
  logic [itcs_pkg::RotW-1:0]   win_end_q;

  // Sequencer state
  logic [itcs_pkg::RotW-1:0]   rot_ticks_q,   rot_ticks_d;
  logic [itcs_pkg::ValveW-1:0] valve_ticks_q, valve_ticks_d;
  logic                        full_q,        full_d;
  logic                        filled_q,      filled_d;
  logic                        rotate_q,      rotate_d;
  logic                        edge_q,        edge_d;
  logic                        saw_low_q,     saw_low_d;
  itcs_pkg::motor_e            motor_q,       motor_d;
  logic                        valve_q,       valve_d;

  // Output register
  logic                        out_valid_q;
  itcs_pkg::result_t           result_q;

  logic in_xfer;
  logic cfg_xfer;

  // An item is taken whenever the result slot is free or draining now.
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_xfer     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_xfer    = cfg_i.valid;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= itcs_pkg::ThresholdRst;
      fill_limit_q <= itcs_pkg::FillLimitRst;
      win_start_q  <= itcs_pkg::WinStartRst;
      win_end_q    <= itcs_pkg::WinEndRst;
    end else if (cfg_xfer) begin
      case (cfg_i.index)
        itcs_pkg::RegThreshold: threshold_q  <= cfg_i.wdata[itcs_pkg::TempW-1:0];
        itcs_pkg::RegFillLimit: fill_limit_q <= cfg_i.wdata[itcs_pkg::ValveW-1:0];
        itcs_pkg::RegWinStart:  win_start_q  <= cfg_i.wdata[itcs_pkg::RotW-1:0];
        itcs_pkg::RegWinEnd:    win_end_q    <= cfg_i.wdata[itcs_pkg::RotW-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Next state for one item
  // --------------------------------------------------------------------------
  always_comb begin
    rot_ticks_d   = rot_ticks_q;
    valve_ticks_d = valve_ticks_q;
    full_d        = full_q;
    filled_d      = filled_q;
    rotate_d      = rotate_q;
    edge_d        = edge_q;
    saw_low_d     = saw_low_q;
    motor_d       = motor_q;
    valve_d       = valve_q;

    if (in_i.kind == itcs_pkg::KindTick) begin
      // Timers saturate at all-ones.
      if (valve_ticks_q != '1) begin
        valve_ticks_d = valve_ticks_q + 1'b1;
      end
      if (rotate_q) begin
        if (rot_ticks_q != '1) begin
          rot_ticks_d = rot_ticks_q + 1'b1;
        end
      end else if (rot_ticks_q > itcs_pkg::IdleRotWrap) begin
        rot_ticks_d = '0;
      end
    end else begin
      // Fill control is frozen while the bin is full.
      if (!full_q) begin
        if (valve_ticks_q > fill_limit_q) begin
          valve_d  = 1'b0;
          filled_d = 1'b1;
        end else begin
          valve_d  = 1'b1;
          filled_d = 1'b0;
        end
      end

      if (filled_d && (in_i.temp_reading >= threshold_q)) begin
        rotate_d = 1'b1;
      end

      if (rotate_d) begin
        // Hall window: low then high marks an edge (empty window never samples).
        if ((rot_ticks_q >= win_start_q) && (rot_ticks_q <= win_end_q)) begin
          if (!in_i.hall_level) begin
            saw_low_d = 1'b1;
          end else if (saw_low_q) begin
            edge_d    = 1'b1;
            saw_low_d = 1'b0;
          end
        end

        if (rot_ticks_q <= itcs_pkg::SchedFwdEnd) begin
          motor_d = itcs_pkg::MotorFwd;
        end else if (!edge_d) begin
          // Container empty schedule
          if (rot_ticks_q <= itcs_pkg::EmptyFwdEnd) begin
            motor_d = itcs_pkg::MotorFwd;
          end else if (rot_ticks_q <= itcs_pkg::EmptyStop1End) begin
            motor_d = itcs_pkg::MotorStop;
          end else if (rot_ticks_q <= itcs_pkg::EmptyRevEnd) begin
            motor_d = itcs_pkg::MotorRev;
          end else if (rot_ticks_q <= itcs_pkg::EmptyStop2End) begin
            motor_d = itcs_pkg::MotorStop;
          end else begin
            rot_ticks_d   = '0;
            edge_d        = 1'b0;
            full_d        = 1'b0;
            rotate_d      = 1'b0;
            filled_d      = 1'b0;
            valve_ticks_d = '0;
          end
        end else begin
          // Container full schedule
          if (rot_ticks_q <= itcs_pkg::FullStop1End) begin
            motor_d = itcs_pkg::MotorStop;
          end else if (rot_ticks_q <= itcs_pkg::FullRevEnd) begin
            motor_d = itcs_pkg::MotorRev;
          end else if (rot_ticks_q <= itcs_pkg::FullStop2End) begin
            motor_d = itcs_pkg::MotorStop;
          end else begin
            rot_ticks_d   = '0;
            edge_d        = 1'b0;
            full_d        = 1'b1;
            rotate_d      = 1'b0;
            filled_d      = 1'b1;
            valve_ticks_d = '0;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // State and result registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_ticks_q   <= '0;
      valve_ticks_q <= '0;
      full_q        <= 1'b0;
      filled_q      <= 1'b0;
      rotate_q      <= 1'b0;
      edge_q        <= 1'b0;
      saw_low_q     <= 1'b0;
      motor_q       <= itcs_pkg::MotorStop;
      valve_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_xfer) begin
        rot_ticks_q   <= rot_ticks_d;
        valve_ticks_q <= valve_ticks_d;
        full_q        <= full_d;
        filled_q      <= filled_d;
        rotate_q      <= rotate_d;
        edge_q        <= edge_d;
        saw_low_q     <= saw_low_d;
        motor_q       <= motor_d;
        valve_q       <= valve_d;
        out_valid_q   <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      result_q.motor_drive  <= motor_d;
      result_q.valve_open   <= valve_d;
      result_q.water_filled <= filled_d;
      result_q.rotating     <= rotate_d;
      result_q.hall_seen    <= edge_d;
      result_q.bin_full     <= full_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.motor_drive  = result_q.motor_drive;
  assign out_o.valve_open   = result_q.valve_open;
  assign out_o.water_filled = result_q.water_filled;
  assign out_o.rotating     = result_q.rotating;
  assign out_o.hall_seen    = result_q.hall_seen;
  assign out_o.bin_full     = result_q.bin_full;

endmodule

`default_nettype wire

// ===== rtl/itcs_checker.sv =====
// ----------------------------------------------------------------------------
// itcs_checker
// Port-level assertions for the ice tray cycle sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module itcs_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic [itcs_pkg::MotorW-1:0] motor_drive_i,
  input wire logic                        water_filled_i,
  input wire logic                        rotating_i,
  input wire logic                        hall_seen_i,
  input wire logic                        bin_full_i
);

  logic out_stall;
  assign out_stall = out_valid_i && !out_ready_i;

  // A stalled result stays offered and unchanged.
  `ITCS_ASSERT(a_out_hold, out_stall |=> out_valid_i, "result dropped while stalled")
  `ITCS_ASSERT(a_out_stable, out_stall |=> $stable(motor_drive_i) && $stable(bin_full_i), "stalled result changed")

  // Motor code is one of stop, forward, reverse.
  `ITCS_ASSERT_WHEN(a_motor_code, out_valid_i, motor_drive_i != 2'd3, "bad motor code")

  // Hall edge is only latched during a rotation and cleared at its end.
  `ITCS_ASSERT_WHEN(a_hall_in_rot, out_valid_i, !hall_seen_i || rotating_i, "hall flag outside rotation")

  // A full bin is only declared together with water filled.
  `ITCS_ASSERT_WHEN(a_full_filled, out_valid_i, !bin_full_i || water_filled_i, "full without filled")

endmodule

bind ice_tray_cycle_sequencer itcs_checker u_itcs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .motor_drive_i  (out_o.motor_drive),
  .water_filled_i (out_o.water_filled),
  .rotating_i     (out_o.rotating),
  .hall_seen_i    (out_o.hall_seen),
  .bin_full_i     (out_o.bin_full)
);

`default_nettype wire

// ===== tb/itcs_tray_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itcs_tray_checker
// Tracks the sequencer's state from observed item and register transfers
// and compares every status transfer, in order, against its prediction.
// ----------------------------------------------------------------------------
module itcs_tray_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  itcs_in_if          item_i,
  itcs_out_if         status_i,
  itcs_cfg_if         cfg_i,
  output int unsigned mismatches_o,
  output int unsigned backlog_o
);
  import itcs_pkg::*;

  typedef struct packed {
    logic [TempW-1:0]  threshold;
    logic [ValveW-1:0] fill_limit;
    logic [RotW-1:0]   win_start;
    logic [RotW-1:0]   win_end;
  } tray_regs_t;

  typedef struct packed {
    logic [RotW-1:0]   rot_ticks;
    logic [ValveW-1:0] valve_ticks;
    logic              full;
    logic              filled;
    logic              rotate;
    logic              hall_edge;
    logic              saw_low;
    motor_e            motor;
    logic              valve;
  } tray_state_t;

  tray_regs_t  regs;
  tray_state_t tray;
  result_t     status_q[$];
  int unsigned misses = 0;
  int unsigned results = 0;

  // End of a harvest pass: timers and cycle flags cleared, bin verdict kept.
  function automatic tray_state_t end_harvest(tray_state_t s, logic bin_full);
    s.rot_ticks   = '0;
    s.valve_ticks = '0;
    s.hall_edge   = 1'b0;
    s.rotate      = 1'b0;
    s.full        = bin_full;
    s.filled      = bin_full;
    return s;
  endfunction

  function automatic tray_state_t next_tray_state(tray_state_t s, tray_regs_t r,
                                                  logic kind, logic level,
                                                  logic [TempW-1:0] temp);
    logic [RotW-1:0] t;
    if (kind == KindTick) begin
      if (s.valve_ticks != '1) s.valve_ticks = s.valve_ticks + 1'b1;
      if (s.rotate) begin
        if (s.rot_ticks != '1) s.rot_ticks = s.rot_ticks + 1'b1;
      end else if (s.rot_ticks > IdleRotWrap) begin
        s.rot_ticks = '0;
      end
      return s;
    end
    // poll: valve and fill flag only move while the bin is not full
    if (!s.full) begin
      s.valve  = !(s.valve_ticks > r.fill_limit);
      s.filled = (s.valve_ticks > r.fill_limit);
    end
    if (s.filled && temp >= r.threshold) s.rotate = 1'b1;
    if (!s.rotate) return s;

    t = s.rot_ticks;
    if (t >= r.win_start && t <= r.win_end) begin
      if (!level) begin
        s.saw_low = 1'b1;
      end else if (s.saw_low) begin
        s.hall_edge = 1'b1;
        s.saw_low   = 1'b0;
      end
    end

    if (t <= SchedFwdEnd) s.motor = MotorFwd;
    else if (!s.hall_edge) begin
      if (t <= EmptyFwdEnd) s.motor = MotorFwd;
      else if (t <= EmptyStop1End) s.motor = MotorStop;
      else if (t <= EmptyRevEnd) s.motor = MotorRev;
      else if (t <= EmptyStop2End) s.motor = MotorStop;
      else s = end_harvest(s, 1'b0);
    end else begin
      if (t <= FullStop1End) s.motor = MotorStop;
      else if (t <= FullRevEnd) s.motor = MotorRev;
      else if (t <= FullStop2End) s.motor = MotorStop;
      else s = end_harvest(s, 1'b1);
    end
    return s;
  endfunction

  function automatic string show(result_t r);
    return $sformatf("motor=%0d valve=%0d filled=%0d rot=%0d hall=%0d full=%0d",
                     r.motor_drive, r.valve_open, r.water_filled, r.rotating,
                     r.hall_seen, r.bin_full);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t got;
    result_t want;
    if (!rst_ni) begin
      regs = '{threshold: ThresholdRst, fill_limit: FillLimitRst,
               win_start: WinStartRst, win_end: WinEndRst};
      tray = '0;
      status_q.delete();
      backlog_o    <= 0;
      mismatches_o <= misses;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          RegThreshold: regs.threshold  = cfg_i.wdata[TempW-1:0];
          RegFillLimit: regs.fill_limit = cfg_i.wdata[ValveW-1:0];
          RegWinStart:  regs.win_start  = cfg_i.wdata[RotW-1:0];
          RegWinEnd:    regs.win_end    = cfg_i.wdata[RotW-1:0];
          default: ;
        endcase
      end

      // compare before pushing: a status never belongs to the item taken
      // at the same edge
      if (status_i.valid && status_i.ready) begin
        got = '{motor_drive: status_i.motor_drive, valve_open: status_i.valve_open,
                water_filled: status_i.water_filled, rotating: status_i.rotating,
                hall_seen: status_i.hall_seen, bin_full: status_i.bin_full};
        results++;
        if (status_q.size() == 0) begin
          if (misses < 10) $display("status #%0d with no item pending: %s", results,
                                    show(got));
          misses++;
        end else begin
          want = status_q.pop_front();
          if (got.motor_drive !== want.motor_drive || got.valve_open !== want.valve_open ||
              got.water_filled !== want.water_filled || got.rotating !== want.rotating ||
              got.hall_seen !== want.hall_seen || got.bin_full !== want.bin_full) begin
            if (misses < 10) $display("status #%0d mismatch: expected %s, got %s",
                                      results, show(want), show(got));
            misses++;
          end
        end
      end

      if (item_i.valid && item_i.ready) begin
        tray = next_tray_state(tray, regs, item_i.kind, item_i.hall_level,
                               item_i.temp_reading);
        status_q.push_back('{motor_drive: tray.motor, valve_open: tray.valve,
                             water_filled: tray.filled, rotating: tray.rotate,
                             hall_seen: tray.hall_edge, bin_full: tray.full});
      end

      backlog_o    <= status_q.size();
      mismatches_o <= misses;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives tick and poll items and register writes into the ice tray
// sequencer under random idling on both channels; the checker beside the
// block predicts each status transfer and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;
  import itcs_pkg::*;

  // Generous margin over the slowest legal run (about 1.2k items, each with
  // random idling on each side, plus one long receiver hold).
  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned HoldAfter  = 500;   // status count that triggers the hold
  localparam int unsigned HoldCycles = 300;   // length of the long receiver hold
  localparam int unsigned PhaseItems = 120;

  logic        clk_i;
  logic        rst_ni;
  logic        quiet;        // no idling on either side while set
  int unsigned mismatches;
  int unsigned backlog;
  int unsigned cycles = 0;

  itcs_in_if  item_if ();
  itcs_out_if status_if ();
  itcs_cfg_if reg_if ();

  ice_tray_cycle_sequencer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (item_if),
    .out_o  (status_if),
    .cfg_i  (reg_if)
  );

  itcs_tray_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_if),
    .status_i     (status_if),
    .cfg_i        (reg_if),
    .mismatches_o (mismatches),
    .backlog_o    (backlog)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a lost status ends here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("ice_tray_cycle_sequencer test failed");
      $finish;
    end
  end

  // Status receiver. After each transfer it draws a random stall; once, it
  // holds off for a long stretch so the output register fills and the block
  // pushes back on the item channel.
  initial begin : status_sink
    int unsigned hold;
    int unsigned taken;
    hold  = 0;
    taken = 0;
    status_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (status_if.valid && status_if.ready) begin
        taken++;
        if (taken == HoldAfter) hold = HoldCycles;
        else hold = quiet ? 0 : $urandom_range(0, 9);
      end else if (hold > 0) begin
        hold--;
      end
      status_if.ready <= (hold == 0);
    end
  end

  // One item transfer. valid is left high on return so back-to-back items
  // never lower and raise it in the same step.
  task automatic send_item(input logic kind, input logic level,
                           input logic [TempW-1:0] temp);
    int unsigned gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid        <= 1'b1;
    item_if.kind         <= kind;
    item_if.hall_level   <= level;
    item_if.temp_reading <= temp;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
  endtask

  // hall and temp are don't-care on a tick; randomize them anyway
  task automatic send_ticks(input int unsigned n);
    repeat (n) send_item(KindTick, 1'($urandom), TempW'($urandom));
  endtask

  task automatic send_poll(input logic level, input logic [TempW-1:0] temp);
    send_item(KindPoll, level, temp);
  endtask

  // Waits until every predicted status has been seen.
  task automatic drain();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (backlog != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                           input logic [CfgDataW-1:0] data);
    reg_if.valid <= 1'b1;
    reg_if.index <= idx;
    reg_if.wdata <= data;
    @(posedge clk_i);
    while (!reg_if.ready) @(posedge clk_i);
  endtask

  // Writes all four registers, with junk in the unused upper bits of the three
  // narrower ones, plus one write to an unmapped index that must be dropped.
  task automatic program_regs(input logic [TempW-1:0] thr, input logic [ValveW-1:0] fill,
                              input logic [RotW-1:0] ws, input logic [RotW-1:0] we);
    drain();
    write_reg(RegThreshold, thr);
    write_reg(RegFillLimit, {4'($urandom), fill});
    write_reg(RegWinStart, {6'($urandom), ws});
    write_reg(RegWinEnd, {6'($urandom), we});
    write_reg(CfgIdxW'($urandom_range(RegWinEnd + 1, (1 << CfgIdxW) - 1)),
              CfgDataW'($urandom));
    reg_if.valid <= 1'b0;
  endtask

  // Readings cluster around the threshold so rotation starts often.
  function automatic logic [TempW-1:0] pick_temp(input logic [TempW-1:0] thr);
    case ($urandom_range(0, 5))
      0: return thr;
      1: return thr - 1'b1;
      2: return '1;
      3: return '0;
      4: return TempW'($urandom_range(thr, (1 << TempW) - 1));
      default: return TempW'($urandom);
    endcase
  endfunction

  // Random mix: about a third ticks, the rest polls, occasional tick bursts
  // long enough to run a schedule out or saturate a timer.
  task automatic run_phase(input logic [TempW-1:0] thr, input int unsigned n);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 39) == 0) quiet = ~quiet;
      if ($urandom_range(0, 49) == 0) begin
        burst = $urandom_range(20, 70);
        send_ticks(burst);
        sent += burst;
      end else if ($urandom_range(0, 99) < 35) begin
        send_ticks(1);
        sent++;
      end else begin
        send_poll(1'($urandom), pick_temp(thr));
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    logic [TempW-1:0]  thr;
    logic [ValveW-1:0] fill;
    logic [RotW-1:0]   ws;
    item_if.valid        <= 1'b0;
    item_if.kind         <= KindTick;
    item_if.hall_level   <= 1'b0;
    item_if.temp_reading <= '0;
    reg_if.valid         <= 1'b0;
    reg_if.index         <= RegThreshold;
    reg_if.wdata         <= '0;
    rst_ni               <= 1'b0;
    quiet = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pass: fill limit 0, threshold 100, hall window 1..2.
    // Open valve, fill, reading just below then at threshold, hall low then
    // high inside the window, then the whole full-container schedule and a
    // restart while the bin is full.
    program_regs(TempW'(100), '0, RotW'(1), RotW'(2));
    send_poll(1'b0, '0);
    send_ticks(1);
    send_poll(1'b1, TempW'(99));
    send_poll(1'b1, TempW'(100));
    send_ticks(1);
    send_poll(1'b0, '0);
    send_poll(1'b1, '1);
    send_ticks(3);
    send_poll(1'b1, '1);     // stop after forward
    send_ticks(2);
    send_poll(1'b0, '1);     // reverse
    send_ticks(4);
    send_poll(1'b1, '1);     // stop
    send_ticks(2);
    send_poll(1'b1, '1);     // pass ends, bin full
    send_poll(1'b0, '1);     // bin full: valve held, rotation restarts

    // Reset values.
    program_regs(ThresholdRst, FillLimitRst, WinStartRst, WinEndRst);
    run_phase(ThresholdRst, PhaseItems);

    // Low extremes, window covering every tick; first a rotation left
    // without polls until its timer saturates.
    program_regs('0, '0, '0, '1);
    send_ticks(1);
    send_poll(1'b1, '1);
    send_ticks(70);
    send_poll(1'b0, '1);
    run_phase('0, PhaseItems);

    // High extremes: filling never ends, valve timer saturates.
    program_regs('1, '1, '1, '1);
    send_ticks(260);
    run_phase('1, PhaseItems);

    // Empty hall window (start above end).
    thr = TempW'($urandom);
    ws  = RotW'($urandom_range(1, (1 << RotW) - 1));
    program_regs(thr, ValveW'($urandom_range(0, 20)), ws, RotW'($urandom_range(0, ws - 1)));
    run_phase(thr, PhaseItems);

    // Ready threshold at max, fill limit 0, single-tick window at 0.
    program_regs('1, '0, '0, '0);
    run_phase('1, PhaseItems);

    repeat (2) begin
      thr  = TempW'($urandom);
      fill = ValveW'($urandom_range(0, 30));
      program_regs(thr, fill, RotW'($urandom_range(0, 12)), RotW'($urandom_range(0, 24)));
      run_phase(thr, PhaseItems);
    end

    drain();
    repeat (4) @(posedge clk_i);   // catch any stray status
    if (mismatches == 0) begin
      $display("ice_tray_cycle_sequencer test passed");
    end else begin
      $display("ice_tray_cycle_sequencer test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/itcs_pkg.sv
rtl/itcs_if.sv
rtl/ice_tray_cycle_sequencer.sv
rtl/itcs_checker.sv
tb/itcs_tray_checker.sv
tb/tb_top.sv
